/* hw/rtl/phase_current_capture_kcl_macros.svh */
// Assertion macros shared by the phase current capture RTL.
// Each macro expects the enclosing module to have clk and rst_n.
`ifndef PHASE_CURRENT_CAPTURE_KCL_MACROS_SVH
`define PHASE_CURRENT_CAPTURE_KCL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCCK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCCK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pcck_pkg.sv */
// Types, constants and arithmetic helpers for the phase current capture block.
// No dependencies; used by every RTL module of the block.
package pcck_pkg;

    localparam int ADC_UNITS = 4;
    localparam int ADC_SLOTS = 4;

    localparam int IN_USER_W  = 4;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_USER_W = 4;
    localparam int OUT_DATA_W = 168;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_U  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_V  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_U  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_V  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_W  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 3'd7;

    // Phase indexes.
    localparam logic [1:0] PH_U = 2'd0;
    localparam logic [1:0] PH_V = 2'd1;
    localparam logic [1:0] PH_W = 2'd2;

    localparam logic signed [34:0] CUR_MAX = 35'sd8388607;
    localparam logic signed [34:0] CUR_MIN = -35'sd8388608;

    typedef struct packed {
        logic [14:0]       routing;
        logic [2:0][15:0]  bias;
        logic [2:0][15:0]  gain;
        logic [15:0]       pair_window_us;
    } cfg_t;

    // One classified item: which phases update, their bias-corrected volts.
    typedef struct packed {
        logic [2:0]        hit;
        logic [2:0][16:0]  diff;
        logic [31:0]       now_us;
    } entry_t;

    typedef struct packed {
        logic [2:0][23:0]  current;
        logic [2:0][31:0]  count;
        logic [2:0]        mask;
        logic              derived;
    } result_t;

    typedef enum logic [2:0] {
        ST_CONV_U,
        ST_KCL_U,
        ST_CONV_V,
        ST_KCL_V,
        ST_CONV_W,
        ST_RESULT
    } back_state_t;

    function automatic logic [23:0] sat24(input logic signed [34:0] v);
        logic [23:0] r;
        if (v > CUR_MAX)
        begin
            r = 24'h7FFFFF;
        end else if (v < CUR_MIN)
        begin
            r = 24'h800000;
        end else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/pcck_front.sv */
// Front end: decodes the phase routing against an incoming beat and queues
// the phases to update with their bias-corrected voltages. Uses pcck_pkg.
module pcck_front (
    input  pcck_pkg::cfg_t              cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [3:0]                  s_tuser,
    input  logic [95:0]                 s_tdata,
    input  logic                        q_full,
    output logic                        push,
    output pcck_pkg::entry_t            entry
);
    import pcck_pkg::*;

    logic [1:0]       unit;
    logic             item_ok;
    logic [3:0][15:0] slots;

    assign unit    = s_tuser[1:0];
    assign item_ok = s_tuser[2] && s_tuser[3];
    assign slots   = s_tdata[95:32];

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        logic [4:0]  r;
        logic [1:0]  ru;
        logic [1:0]  rs;
        logic [15:0] volts;
        entry.now_us = s_tdata[31:0];
        entry.hit    = '0;
        entry.diff   = '0;
        for (int p = 0; p < 3; p++)
        begin
            r  = cfg.routing[5*p +: 5];
            ru = r[2:1];
            rs = r[4:3];
            volts = slots[rs];
            entry.diff[p] = {1'b0, volts} - {1'b0, cfg.bias[p]};
            entry.hit[p]  = item_ok && r[0] && (32'(ru) < ADC_UNITS)
                            && (32'(rs) < ADC_SLOTS) && (ru == unit)
                            && (cfg.gain[p] != 16'd0);
        end
    end

endmodule

/* hw/rtl/pcck_queue.sv */
// Small flop-based FIFO that decouples the front end from the sequencer.
// Uses pcck_pkg for the entry type and the shared assertion macros.
`include "phase_current_capture_kcl_macros.svh"
module pcck_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcck_pkg::entry_t    entry_in,
    input  logic                pop,
    output pcck_pkg::entry_t    head,
    output logic                valid,
    output logic                full
);
    import pcck_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    `PCCK_ASSERT_NOW(a_no_push_full, full, !push, "push into a full queue")
    `PCCK_ASSERT_NOW(a_no_pop_empty, pop, valid, "pop from an empty queue")
    `PCCK_ASSERT_NEXT(a_push_visible, push && !pop, valid, "queue empty right after a push")

endmodule

/* hw/rtl/pcck_back.sv */
// Back end: walks U, W derivation, V, W derivation and measured W for one
// queued item with a shared multiplier, holds the phase state, and owns the
// output register. Uses pcck_pkg and the shared assertion macros.
`include "phase_current_capture_kcl_macros.svh"
module pcck_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pcck_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  pcck_pkg::entry_t    head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output pcck_pkg::result_t   result
);
    import pcck_pkg::*;

    back_state_t        state_reg, state_next;
    logic signed [23:0] cur_reg [3];
    logic signed [23:0] cur_next [3];
    logic [31:0]        cnt_reg [3];
    logic [31:0]        cnt_next [3];
    logic [31:0]        stamp_reg [3];
    logic [31:0]        stamp_next [3];
    logic               derived_reg, derived_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [1:0]         ph;
    logic [1:0]         partner;
    logic               do_conv;
    logic               do_kcl;
    logic               load_out;

    logic signed [16:0] diff_s;
    logic signed [16:0] gain_s;
    logic signed [33:0] prod;
    logic signed [34:0] rounded;
    logic [23:0]        conv_val;
    logic signed [34:0] neg_sum;
    logic [23:0]        derived_val;
    logic [31:0]        dt;
    logic               kcl_ok;

    // Phase selected by the sequencer step.
    always_comb
    begin
        case (state_reg)
            ST_CONV_U, ST_KCL_U:
            begin
                ph      = PH_U;
                partner = PH_V;
            end
            ST_CONV_V, ST_KCL_V:
            begin
                ph      = PH_V;
                partner = PH_U;
            end
            default:
            begin
                ph      = PH_W;
                partner = PH_U;
            end
        endcase
    end

    // Shared conversion: (volts - bias) * gain / 256, rounded half up, saturated.
    assign diff_s   = signed'(head.diff[ph]);
    assign gain_s   = signed'({1'b0, cfg.gain[ph]});
    assign prod     = diff_s * gain_s;
    assign rounded  = (35'(prod) + 35'sd128) >>> 8;
    assign conv_val = sat24(rounded);

    // Kirchhoff completion of W from the stored U and V currents.
    assign neg_sum     = -(35'(cur_reg[0]) + 35'(cur_reg[1]));
    assign derived_val = sat24(neg_sum);
    assign dt          = head.now_us - stamp_reg[partner];
    assign kcl_ok      = head.hit[ph] && (cnt_reg[partner] != 32'd0)
                         && (dt <= {16'd0, cfg.pair_window_us});

    always_comb
    begin
        state_next     = state_reg;
        derived_next   = derived_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        stamp_next     = stamp_reg;
        do_conv        = 1'b0;
        do_kcl         = 1'b0;
        load_out       = 1'b0;
        q_pop          = 1'b0;

        case (state_reg)
            ST_CONV_U:
            begin
                if (q_valid)
                begin
                    do_conv      = 1'b1;
                    derived_next = 1'b0;
                    state_next   = ST_KCL_U;
                end
            end
            ST_KCL_U:
            begin
                do_kcl     = 1'b1;
                state_next = ST_CONV_V;
            end
            ST_CONV_V:
            begin
                do_conv    = 1'b1;
                state_next = ST_KCL_V;
            end
            ST_KCL_V:
            begin
                do_kcl     = 1'b1;
                state_next = ST_CONV_W;
            end
            ST_CONV_W:
            begin
                do_conv    = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    load_out   = 1'b1;
                    q_pop      = 1'b1;
                    state_next = ST_CONV_U;
                end
            end
            default:
            begin
                state_next = ST_CONV_U;
            end
        endcase

        if (do_conv && head.hit[ph])
        begin
            cur_next[ph]   = signed'(conv_val);
            cnt_next[ph]   = cnt_reg[ph] + 32'd1;
            stamp_next[ph] = head.now_us;
        end

        if (do_kcl && kcl_ok)
        begin
            cur_next[PH_W]   = signed'(derived_val);
            cnt_next[PH_W]   = cnt_reg[PH_W] + 32'd1;
            stamp_next[PH_W] = head.now_us;
            derived_next     = 1'b1;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            for (int p = 0; p < 3; p++)
            begin
                out_next.current[p] = cur_reg[p];
                out_next.count[p]   = cnt_reg[p];
            end
            out_next.mask    = head.hit;
            out_next.derived = derived_reg;
        end else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CONV_U;
            derived_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < 3; p++)
            begin
                cur_reg[p]   <= '0;
                cnt_reg[p]   <= '0;
                stamp_reg[p] <= '0;
            end
        end else
        begin
            state_reg     <= state_next;
            derived_reg   <= derived_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            stamp_reg     <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

    `PCCK_ASSERT_NOW(a_pop_in_result, q_pop, (state_reg == ST_RESULT) && q_valid,
        "queue popped outside the result step")
    `PCCK_ASSERT_NEXT(a_wait_for_item, (state_reg == ST_CONV_U) && !q_valid,
        state_reg == ST_CONV_U, "sequencer started without a queued item")
    `PCCK_ASSERT_NOW(a_derive_needs_uv, load_out && derived_reg,
        head.hit[PH_U] || head.hit[PH_V], "W derived without a U or V update")

endmodule

/* hw/rtl/phase_current_capture_kcl.sv */
// Top level of the three-phase current capture block with KCL completion.
// Holds the configuration registers; instantiates pcck_front, pcck_queue
// and pcck_back. Uses pcck_pkg.
//
// Usage:
//   One input beat on the s_ channel is one injected ADC completion. The
//   front end decodes which phases it feeds and queues them; the back end
//   converts U, V and W in turn with one shared multiplier, derives
//   W = -(U+V) when a U/V pair lies within the pair window, and presents
//   one result beat per input beat on the m_ channel with the stored state.
//   The back end takes one queued item at a time through its six-step walk
//   (three conversions, two pair checks, one result load) and starts the
//   next item only after the result load, which waits while the output
//   register still holds a result that the receiver has not taken.
//   Input beats are taken while earlier ones are still being processed, as
//   long as the QUEUE_DEPTH-entry queue has room.
//   Configuration beats are taken every cycle (cfg_ready is tied high) and
//   must only be sent while no item is in flight.
//   Reset zeroes the configuration, currents, counters, time stamps and
//   valid flags and empties the queue; the result data register is not reset.
//   When m_tready is held low, the result stays in the output register,
//   the back end waits, the queue fills and s_tready drops; nothing is lost.
module phase_current_capture_kcl #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input beat.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tuser from bit 0: adc_unit[1:0], conversion_ok, time_valid.
    input  logic [pcck_pkg::IN_USER_W-1:0]      s_tuser,
    // s_tdata from bit 0: now_us[31:0], slot0_volts, slot1_volts,
    // slot2_volts, slot3_volts (16 bits each).
    input  logic [pcck_pkg::IN_DATA_W-1:0]      s_tdata,
    // Result beat.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tuser from bit 0: updated_mask[2:0], w_derived.
    output logic [pcck_pkg::OUT_USER_W-1:0]     m_tuser,
    // m_tdata from bit 0: current_u, current_v, current_w (24 bits each),
    // count_u, count_v, count_w (32 bits each).
    output logic [pcck_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcck_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcck_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pcck_pkg::*;

    cfg_t    cfg_reg;
    logic    push;
    entry_t  entry;
    logic    q_pop;
    entry_t  head;
    logic    q_valid;
    logic    q_full;
    result_t result;

    assign cfg_ready = 1'b1;

    // Register file. Writes land on a completed configuration beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROUTING: cfg_reg.routing        <= cfg_data[14:0];
                CFG_BIAS_U:  cfg_reg.bias[PH_U]     <= cfg_data;
                CFG_BIAS_V:  cfg_reg.bias[PH_V]     <= cfg_data;
                CFG_BIAS_W:  cfg_reg.bias[PH_W]     <= cfg_data;
                CFG_GAIN_U:  cfg_reg.gain[PH_U]     <= cfg_data;
                CFG_GAIN_V:  cfg_reg.gain[PH_V]     <= cfg_data;
                CFG_GAIN_W:  cfg_reg.gain[PH_W]     <= cfg_data;
                CFG_WINDOW:  cfg_reg.pair_window_us <= cfg_data;
                default:     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front end: classify the beat and compute bias-corrected voltages.
    pcck_front u_front (
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .entry    (entry)
    );

    // Queue between front and back so either side can stall on its own.
    pcck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .entry_in (entry),
        .pop      (q_pop),
        .head     (head),
        .valid    (q_valid),
        .full     (q_full)
    );

    // Back end: per-phase sequencer, phase state and output register.
    pcck_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .head    (head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .result  (result)
    );

    assign m_tdata = {result.count[PH_W], result.count[PH_V], result.count[PH_U],
                      result.current[PH_W], result.current[PH_V], result.current[PH_U]};
    assign m_tuser = {result.derived, result.mask};

endmodule
